[hw/rtl/brdh_pkg.sv]
// Shared constants, codes and structures of the batch row deduplication block.
package brdh_pkg;

    // MAX_BATCH must be a power of two.
    localparam int MAX_BATCH  = 256;
    localparam int TABLE_SIZE = 2 * MAX_BATCH;
    localparam int TBITS      = $clog2(TABLE_SIZE);
    localparam int REF_W      = $clog2(MAX_BATCH);
    localparam int CNT_W      = $clog2(MAX_BATCH + 1);
    localparam int PROBE_W    = TBITS + 1;

    localparam int ROW_W      = 64;
    localparam int GEN_W      = 32;
    localparam int UIDX_W     = 8;
    localparam int UCNT_W     = 9;
    localparam int HALF_W     = ROW_W / 2;

    localparam logic [ROW_W-1:0] FIB_MULT = 64'h9E37_79B9_7F4A_7C15;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_HASH,
        S_SLOT_RD,
        S_SLOT_CHK,
        S_ROW_CHK,
        S_DONE
    } seq_state_t;

    typedef enum logic [2:0] {
        MS_IDLE,
        MS_LL,
        MS_HL,
        MS_LH,
        MS_ACC
    } mul_step_t;

    typedef struct packed {
        logic [GEN_W-1:0] gen;
        logic [REF_W-1:0] uref;
    } slot_t;

    typedef struct packed {
        logic             slot_we;
        logic [TBITS-1:0] slot_waddr;
        slot_t            slot_wdata;
        logic [TBITS-1:0] slot_raddr;
        logic             row_we;
        logic [REF_W-1:0] row_waddr;
        logic [ROW_W-1:0] row_wdata;
        logic [REF_W-1:0] row_raddr;
    } mem_req_t;

    typedef struct packed {
        logic [REF_W-1:0] index;
        logic             is_new;
        status_t          status;
        logic [CNT_W-1:0] count;
    } result_t;

endpackage

[hw/rtl/brdh_hash.sv]
// Fibonacci hash: 64-bit product built over four steps of one 32x32 multiplier.
module brdh_hash (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [brdh_pkg::ROW_W-1:0]   row,
    output logic                         done,
    output logic [brdh_pkg::TBITS-1:0]   pos
);

    brdh_pkg::mul_step_t step_reg, step_next;

    logic                           done_reg;
    logic [brdh_pkg::ROW_W-1:0]     a_reg;
    logic [brdh_pkg::ROW_W-1:0]     prod_reg;
    logic [brdh_pkg::ROW_W-1:0]     acc_reg;
    logic [brdh_pkg::HALF_W-1:0]    mul_a;
    logic [brdh_pkg::HALF_W-1:0]    mul_b;
    logic [brdh_pkg::ROW_W-1:0]     mul_p;
    logic [brdh_pkg::ROW_W-1:0]     prod_shift;

    always_comb
    begin
        step_next = step_reg;
        unique case (step_reg)
            brdh_pkg::MS_IDLE: if (start) step_next = brdh_pkg::MS_LL;
            brdh_pkg::MS_LL:   step_next = brdh_pkg::MS_HL;
            brdh_pkg::MS_HL:   step_next = brdh_pkg::MS_LH;
            brdh_pkg::MS_LH:   step_next = brdh_pkg::MS_ACC;
            brdh_pkg::MS_ACC:  step_next = brdh_pkg::MS_IDLE;
            default:           step_next = brdh_pkg::MS_IDLE;
        endcase
    end

    always_comb
    begin
        mul_a = a_reg[brdh_pkg::HALF_W-1:0];
        mul_b = brdh_pkg::FIB_MULT[brdh_pkg::HALF_W-1:0];
        unique case (step_reg)
            brdh_pkg::MS_HL: mul_a = a_reg[brdh_pkg::ROW_W-1:brdh_pkg::HALF_W];
            brdh_pkg::MS_LH: mul_b = brdh_pkg::FIB_MULT[brdh_pkg::ROW_W-1:brdh_pkg::HALF_W];
            default:
            begin
            end
        endcase
    end

    assign mul_p      = {{brdh_pkg::HALF_W{1'b0}}, mul_a} * {{brdh_pkg::HALF_W{1'b0}}, mul_b};
    assign prod_shift = {prod_reg[brdh_pkg::HALF_W-1:0], {brdh_pkg::HALF_W{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= brdh_pkg::MS_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= (step_reg == brdh_pkg::MS_ACC);
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_reg == brdh_pkg::MS_IDLE && start)
        begin
            a_reg <= row;
        end
        if (step_reg != brdh_pkg::MS_IDLE && step_reg != brdh_pkg::MS_ACC)
        begin
            prod_reg <= mul_p;
        end
        unique case (step_reg)
            brdh_pkg::MS_HL:  acc_reg <= prod_reg;
            brdh_pkg::MS_LH:  acc_reg <= acc_reg + prod_shift;
            brdh_pkg::MS_ACC: acc_reg <= acc_reg + prod_shift;
            default:
            begin
            end
        endcase
    end

    assign done = done_reg;
    assign pos  = acc_reg[brdh_pkg::ROW_W-1 -: brdh_pkg::TBITS];

endmodule

[hw/rtl/brdh_mem.sv]
// Slot table (generation tag and unique reference) and unique row store.
module brdh_mem (
    input  logic                         clk,
    input  brdh_pkg::mem_req_t           req,
    output brdh_pkg::slot_t              slot_rd,
    output logic [brdh_pkg::ROW_W-1:0]   row_rd
);

    brdh_pkg::slot_t            slot_mem [brdh_pkg::TABLE_SIZE];
    logic [brdh_pkg::ROW_W-1:0] row_mem  [brdh_pkg::MAX_BATCH];

    brdh_pkg::slot_t            slot_rd_reg;
    logic [brdh_pkg::ROW_W-1:0] row_rd_reg;

    always_ff @(posedge clk)
    begin
        if (req.slot_we)
        begin
            slot_mem[req.slot_waddr] <= req.slot_wdata;
        end
        slot_rd_reg <= slot_mem[req.slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (req.row_we)
        begin
            row_mem[req.row_waddr] <= req.row_wdata;
        end
        row_rd_reg <= row_mem[req.row_raddr];
    end

    assign slot_rd = slot_rd_reg;
    assign row_rd  = row_rd_reg;

endmodule

[hw/rtl/brdh_seq.sv]
// Sequencer: batch bookkeeping, range and overflow checks, linear probing.
module brdh_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         row_valid,
    output logic                         row_stall,
    input  logic [brdh_pkg::ROW_W-1:0]   row_id,
    input  logic                         starts_batch,
    input  logic [brdh_pkg::ROW_W-1:0]   row_limit,
    output logic                         hash_start,
    output logic [brdh_pkg::ROW_W-1:0]   hash_row,
    input  logic                         hash_done,
    input  logic [brdh_pkg::TBITS-1:0]   hash_pos,
    output brdh_pkg::mem_req_t           mem_req,
    input  brdh_pkg::slot_t              slot_rd,
    input  logic [brdh_pkg::ROW_W-1:0]   row_rd,
    output logic                         res_valid,
    output brdh_pkg::result_t            res,
    input  logic                         res_take
);

    brdh_pkg::seq_state_t state_reg, state_next;

    logic [brdh_pkg::TBITS-1:0]   clr_addr_reg, clr_addr_next;
    logic                         resume_reg, resume_next;
    logic [brdh_pkg::GEN_W-1:0]   gen_reg, gen_next;
    logic [brdh_pkg::CNT_W-1:0]   distinct_reg, distinct_next;
    logic [brdh_pkg::CNT_W-1:0]   batch_reg, batch_next;
    logic [brdh_pkg::PROBE_W-1:0] probes_reg, probes_next;
    logic [brdh_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [brdh_pkg::TBITS-1:0]   pos_reg, pos_next;
    logic [brdh_pkg::REF_W-1:0]   uref_reg, uref_next;
    logic [brdh_pkg::REF_W-1:0]   idx_reg, idx_next;
    logic                         new_reg, new_next;
    brdh_pkg::status_t            status_reg, status_next;

    logic                         begin_batch;
    logic [brdh_pkg::GEN_W-1:0]   gen_inc;
    logic                         gen_wrap;
    logic                         out_of_range;
    logic                         overflow;
    logic                         slot_hit;
    logic                         row_match;

    assign begin_batch  = starts_batch || (gen_reg == '0);
    assign gen_inc      = gen_reg + 1'b1;
    assign gen_wrap     = (gen_inc == '0);
    assign out_of_range = (row_reg >= row_limit);
    assign overflow     = (batch_reg >= brdh_pkg::CNT_W'(brdh_pkg::MAX_BATCH));
    assign slot_hit     = (probes_reg < brdh_pkg::PROBE_W'(brdh_pkg::TABLE_SIZE))
                          && (slot_rd.gen == gen_reg);
    assign row_match    = (row_rd == row_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            brdh_pkg::S_CLEAR:
            begin
                if (clr_addr_reg == brdh_pkg::TBITS'(brdh_pkg::TABLE_SIZE - 1))
                begin
                    state_next = resume_reg ? brdh_pkg::S_CHECK : brdh_pkg::S_IDLE;
                end
            end
            brdh_pkg::S_IDLE:
            begin
                if (row_valid)
                begin
                    state_next = (begin_batch && gen_wrap) ? brdh_pkg::S_CLEAR
                                                           : brdh_pkg::S_CHECK;
                end
            end
            brdh_pkg::S_CHECK:
            begin
                state_next = (out_of_range || overflow) ? brdh_pkg::S_DONE
                                                        : brdh_pkg::S_HASH;
            end
            brdh_pkg::S_HASH:
            begin
                if (hash_done) state_next = brdh_pkg::S_SLOT_RD;
            end
            brdh_pkg::S_SLOT_RD:
            begin
                state_next = brdh_pkg::S_SLOT_CHK;
            end
            brdh_pkg::S_SLOT_CHK:
            begin
                state_next = slot_hit ? brdh_pkg::S_ROW_CHK : brdh_pkg::S_DONE;
            end
            brdh_pkg::S_ROW_CHK:
            begin
                state_next = row_match ? brdh_pkg::S_DONE : brdh_pkg::S_SLOT_RD;
            end
            brdh_pkg::S_DONE:
            begin
                if (res_take) state_next = brdh_pkg::S_IDLE;
            end
            default:
            begin
                state_next = brdh_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        resume_next   = resume_reg;
        gen_next      = gen_reg;
        distinct_next = distinct_reg;
        batch_next    = batch_reg;
        probes_next   = probes_reg;
        row_next      = row_reg;
        pos_next      = pos_reg;
        uref_next     = uref_reg;
        idx_next      = idx_reg;
        new_next      = new_reg;
        status_next   = status_reg;
        hash_start    = 1'b0;

        mem_req            = '0;
        mem_req.slot_waddr = pos_reg;
        mem_req.slot_raddr = pos_reg;
        mem_req.row_raddr  = slot_rd.uref;
        mem_req.row_waddr  = distinct_reg[brdh_pkg::REF_W-1:0];
        mem_req.row_wdata  = row_reg;

        unique case (state_reg)
            brdh_pkg::S_CLEAR:
            begin
                mem_req.slot_we    = 1'b1;
                mem_req.slot_waddr = clr_addr_reg;
                mem_req.slot_wdata = '0;
                clr_addr_next      = clr_addr_reg + 1'b1;
            end
            brdh_pkg::S_IDLE:
            begin
                if (row_valid)
                begin
                    row_next    = row_id;
                    resume_next = 1'b1;
                    if (begin_batch)
                    begin
                        gen_next      = gen_wrap ? brdh_pkg::GEN_W'(1) : gen_inc;
                        distinct_next = '0;
                        batch_next    = '0;
                    end
                end
            end
            brdh_pkg::S_CHECK:
            begin
                idx_next = '0;
                new_next = 1'b0;
                priority if (out_of_range)
                begin
                    status_next = brdh_pkg::ST_RANGE;
                end
                else if (overflow)
                begin
                    status_next = brdh_pkg::ST_OVERFLOW;
                end
                else
                begin
                    status_next = brdh_pkg::ST_OK;
                    batch_next  = batch_reg + 1'b1;
                    hash_start  = 1'b1;
                end
            end
            brdh_pkg::S_HASH:
            begin
                if (hash_done)
                begin
                    pos_next    = hash_pos;
                    probes_next = '0;
                end
            end
            brdh_pkg::S_SLOT_RD:
            begin
            end
            brdh_pkg::S_SLOT_CHK:
            begin
                if (slot_hit)
                begin
                    uref_next = slot_rd.uref;
                end
                else
                begin
                    mem_req.slot_we         = 1'b1;
                    mem_req.slot_wdata.gen  = gen_reg;
                    mem_req.slot_wdata.uref = distinct_reg[brdh_pkg::REF_W-1:0];
                    mem_req.row_we          = 1'b1;
                    idx_next                = distinct_reg[brdh_pkg::REF_W-1:0];
                    new_next                = 1'b1;
                    distinct_next           = distinct_reg + 1'b1;
                end
            end
            brdh_pkg::S_ROW_CHK:
            begin
                if (row_match)
                begin
                    idx_next = uref_reg;
                end
                else
                begin
                    pos_next    = pos_reg + 1'b1;
                    probes_next = probes_reg + 1'b1;
                end
            end
            brdh_pkg::S_DONE:
            begin
                resume_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= brdh_pkg::S_CLEAR;
            clr_addr_reg <= '0;
            resume_reg   <= 1'b0;
            gen_reg      <= '0;
            distinct_reg <= '0;
            batch_reg    <= '0;
            probes_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            resume_reg   <= resume_next;
            gen_reg      <= gen_next;
            distinct_reg <= distinct_next;
            batch_reg    <= batch_next;
            probes_reg   <= probes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg    <= row_next;
        pos_reg    <= pos_next;
        uref_reg   <= uref_next;
        idx_reg    <= idx_next;
        new_reg    <= new_next;
        status_reg <= status_next;
    end

    assign hash_row   = row_reg;
    assign row_stall  = (state_reg != brdh_pkg::S_IDLE);
    assign res_valid  = (state_reg == brdh_pkg::S_DONE);
    assign res.index  = idx_reg;
    assign res.is_new = new_reg;
    assign res.status = status_reg;
    assign res.count  = distinct_reg;

    a_insert_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == brdh_pkg::S_SLOT_CHK && !slot_hit)
            |-> (distinct_reg < brdh_pkg::CNT_W'(brdh_pkg::MAX_BATCH)))
        else $error("slot insert with the unique row store full");

    a_distinct_le_batch: assert property (@(posedge clk) disable iff (!rst_n)
        distinct_reg <= batch_reg)
        else $error("more distinct rows than rows in the batch");

    a_probe_live_gen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == brdh_pkg::S_SLOT_RD) |-> (gen_reg != '0))
        else $error("probe with no batch open");

    a_row_write_pairs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.row_we |-> (mem_req.slot_we
                            && mem_req.slot_wdata.uref == mem_req.row_waddr
                            && mem_req.slot_wdata.gen == gen_reg))
        else $error("row store write without its slot tag");

endmodule

[hw/rtl/batch_row_dedup_hash_top.sv]
// Top level of the batch row deduplication block: ports, limit register, result register.
//
// Input channel (row_valid / row_stall): one word per row, row_id and
// starts_batch. starts_batch opens a new batch and empties the table.
// Output channel (result_valid / result_stall): one word per row with
// unique_index, is_new, status (ok, out of range, batch overflow) and
// unique_count. Configuration channel (cfg_valid / cfg_ready): writes
// row_limit; write it only while no row is in flight.
// Rows are handled one at a time by a sequencer around one 32x32 hash
// multiplier and a slot table with one write and one read port. A rejected
// row goes from the range and overflow check straight to its result; an
// accepted row first passes the hash (four multiplier steps) and a
// registered slot read, and the linear probe adds a registered slot read
// and a registered row read for every occupied slot that it passes over.
// After reset, and when the generation counter wraps, a clearing pass
// writes all 512 slots, one slot a cycle, with row_stall high.
// A finished result sits in the output register while the next row is
// taken; if result_stall holds it, the following result waits inside.
module batch_row_dedup_hash_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        row_valid,
    output logic        row_stall,
    input  logic [63:0] row_id,
    input  logic        starts_batch,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  unique_index,
    output logic        is_new,
    output logic [1:0]  status,
    output logic [8:0]  unique_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] row_limit
);

    logic [brdh_pkg::ROW_W-1:0] row_limit_reg;
    logic                       out_valid_reg, out_valid_next;
    brdh_pkg::result_t          out_res_reg;

    logic                       hash_start;
    logic [brdh_pkg::ROW_W-1:0] hash_row;
    logic                       hash_done;
    logic [brdh_pkg::TBITS-1:0] hash_pos;
    brdh_pkg::mem_req_t         mem_req;
    brdh_pkg::slot_t            slot_rd;
    logic [brdh_pkg::ROW_W-1:0] row_rd;
    logic                       res_valid;
    brdh_pkg::result_t          res;
    logic                       res_take;
    logic [31:0]                idx_wide;
    logic [31:0]                cnt_wide;

    brdh_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .row   (hash_row),
        .done  (hash_done),
        .pos   (hash_pos)
    );

    brdh_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .slot_rd (slot_rd),
        .row_rd  (row_rd)
    );

    brdh_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .row_valid    (row_valid),
        .row_stall    (row_stall),
        .row_id       (row_id),
        .starts_batch (starts_batch),
        .row_limit    (row_limit_reg),
        .hash_start   (hash_start),
        .hash_row     (hash_row),
        .hash_done    (hash_done),
        .hash_pos     (hash_pos),
        .mem_req      (mem_req),
        .slot_rd      (slot_rd),
        .row_rd       (row_rd),
        .res_valid    (res_valid),
        .res          (res),
        .res_take     (res_take)
    );

    assign cfg_ready = 1'b1;
    assign res_take  = res_valid && (!out_valid_reg || !result_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_limit_reg <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                row_limit_reg <= row_limit;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_res_reg <= res;
        end
    end

    assign idx_wide     = 32'(out_res_reg.index);
    assign cnt_wide     = 32'(out_res_reg.count);
    assign result_valid = out_valid_reg;
    assign unique_index = idx_wide[brdh_pkg::UIDX_W-1:0];
    assign is_new       = out_res_reg.is_new;
    assign status       = out_res_reg.status;
    assign unique_count = cnt_wide[brdh_pkg::UCNT_W-1:0];

endmodule

[tb/sv/batch_row_dedup_hash_top_test.sv]
// Self-checking testbench of batch_row_dedup_hash_top: directed and random row batches.
`timescale 1ns / 1ps

module batch_row_dedup_hash_top_test;
    import brdh_pkg::*;

    localparam int QUIET_LIMIT = 20000;

    typedef struct packed {
        logic [UIDX_W-1:0] uidx;
        logic              fresh;
        status_t           st;
        logic [UCNT_W-1:0] ucount;
    } dedup_word_t;

    class row_dedup_tracker;
        logic [ROW_W-1:0] limit;
        logic [GEN_W-1:0] slot_gen [TABLE_SIZE];
        logic [REF_W-1:0] slot_ref [TABLE_SIZE];
        logic [ROW_W-1:0] stored_rows [MAX_BATCH];
        logic [GEN_W-1:0] gen;
        int               distinct;
        int               batch_rows;
        int               errors;
        dedup_word_t      awaited[$];

        function new();
            limit = '1;
            foreach (slot_gen[i]) slot_gen[i] = '0;
            foreach (slot_ref[i]) slot_ref[i] = '0;
            foreach (stored_rows[i]) stored_rows[i] = '0;
            gen        = '0;
            distinct   = 0;
            batch_rows = 0;
            errors     = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_row(logic [ROW_W-1:0] row, logic opens);
            dedup_word_t      w;
            logic [ROW_W-1:0] prod;
            logic [TBITS-1:0] pos;
            logic [REF_W-1:0] idx;
            int               probes;
            bit               found;
            w      = '0;
            w.st   = ST_OK;
            probes = 0;
            found  = 0;
            if (opens || gen == '0) begin
                gen = gen + 1'b1;
                if (gen == '0) begin
                    foreach (slot_gen[i]) slot_gen[i] = '0;
                    gen = 1;
                end
                distinct   = 0;
                batch_rows = 0;
            end
            if (row >= limit) begin
                w.st = ST_RANGE;
            end
            else if (batch_rows >= MAX_BATCH) begin
                w.st = ST_OVERFLOW;
            end
            else begin
                prod = row * FIB_MULT;
                pos  = prod[ROW_W-1 -: TBITS];
                batch_rows++;
                while (!found && probes < TABLE_SIZE && slot_gen[pos] == gen) begin
                    if (stored_rows[slot_ref[pos]] == row) begin
                        found  = 1;
                        w.uidx = slot_ref[pos];
                    end
                    else begin
                        pos = pos + 1'b1;
                        probes++;
                    end
                end
                if (!found) begin
                    idx              = REF_W'(distinct % MAX_BATCH);
                    slot_gen[pos]    = gen;
                    slot_ref[pos]    = idx;
                    stored_rows[idx] = row;
                    distinct++;
                    w.fresh = 1'b1;
                    w.uidx  = idx;
                end
            end
            w.ucount = UCNT_W'(distinct);
            awaited.push_back(w);
        endfunction

        function void field_err(string name, longint unsigned want, longint unsigned got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        endfunction

        function void check_result(logic [UIDX_W-1:0] idx, logic fresh, logic [1:0] st,
                                   logic [UCNT_W-1:0] cnt);
            dedup_word_t want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual index %0d status %0d",
                         $time, idx, st);
                return;
            end
            want = awaited.pop_front();
            if (idx !== want.uidx) field_err("unique_index", want.uidx, idx);
            if (fresh !== want.fresh) field_err("is_new", want.fresh, fresh);
            if (st !== want.st) field_err("status", want.st, st);
            if (cnt !== want.ucount) field_err("unique_count", want.ucount, cnt);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        row_valid;
    logic        row_stall;
    logic [63:0] row_id;
    logic        starts_batch;
    logic        result_valid;
    logic        result_stall;
    logic [7:0]  unique_index;
    logic        is_new;
    logic [1:0]  status;
    logic [8:0]  unique_count;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [63:0] row_limit;

    row_dedup_tracker tracker;
    logic [63:0]      fib_inv;
    bit               calm;
    int               quiet_cycles;

    batch_row_dedup_hash_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .row_valid    (row_valid),
        .row_stall    (row_stall),
        .row_id       (row_id),
        .starts_batch (starts_batch),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .unique_index (unique_index),
        .is_new       (is_new),
        .status       (status),
        .unique_count (unique_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .row_limit    (row_limit)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        result_stall <= !calm && ($urandom_range(0, 99) < 29);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            tracker.check_result(unique_index, is_new, status, unique_count);
    end

    always @(posedge clk)
    begin
        if ((row_valid && !row_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("** batch_row_dedup_hash_top: FAILED **");
            $finish;
        end
    end

    // rows whose hash lands in slot h: the product with the multiplier is {h, c}
    function automatic logic [63:0] bucket_row(input logic [TBITS-1:0] h, input int c);
        return fib_inv * {h, (ROW_W - TBITS)'(c)};
    endfunction

    task automatic send_row(input logic [63:0] rid, input logic opens);
        while (!calm && $urandom_range(0, 99) < 29) begin
            row_valid <= 1'b0;
            @(negedge clk);
        end
        row_valid    <= 1'b1;
        row_id       <= rid;
        starts_batch <= opens;
        @(posedge clk);
        while (row_stall) @(posedge clk);
        tracker.note_row(rid, opens);
        @(negedge clk);
    endtask

    task automatic settle();
        row_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_limit(input logic [63:0] v);
        cfg_valid <= 1'b1;
        row_limit <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        tracker.limit = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [63:0] v, input int n_rows, input bit big_first);
        logic [63:0]      seen[$];
        logic [TBITS-1:0] buckets[2];
        logic [63:0]      rid;
        int               len;
        int               k;
        int               sent;
        bit               first;
        settle();
        write_limit(v);
        sent  = 0;
        first = 1;
        while (sent < n_rows) begin
            len = (first && big_first) ? $urandom_range(262, 300) : $urandom_range(1, 24);
            seen.delete();
            buckets[0] = TBITS'($urandom_range(0, TABLE_SIZE - 1));
            buckets[1] = ($urandom_range(0, 3) == 0) ? '1 : TBITS'($urandom_range(0, 31));
            for (k = 0; k < len; k++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: rid = (seen.size() != 0) ?
                                      seen[$urandom_range(0, seen.size() - 1)] :
                                      {$urandom, $urandom};
                    4, 5: rid = bucket_row(buckets[$urandom_range(0, 1)], $urandom_range(0, 15));
                    6: case ($urandom_range(0, 3))
                           0: rid = '0;
                           1: rid = '1;
                           2: rid = v - 1;
                           default: rid = v;
                       endcase
                    default: rid = {$urandom, $urandom};
                endcase
                seen.push_back(rid);
                send_row(rid, k == 0 || $urandom_range(0, 49) == 0);
                sent++;
            end
            first = 0;
        end
    endtask

    initial
    begin
        int c;
        clk          = 1'b0;
        rst_n        = 1'b0;
        row_valid    = 1'b0;
        row_id       = '0;
        starts_batch = 1'b0;
        result_stall = 1'b0;
        cfg_valid    = 1'b0;
        row_limit    = '1;
        calm         = 0;
        quiet_cycles = 0;
        tracker      = new();
        fib_inv      = FIB_MULT;
        repeat (6) fib_inv = fib_inv * (64'd2 - FIB_MULT * fib_inv);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_limit('1);
        send_row(64'd5, 1'b0);
        send_row(64'd5, 1'b0);
        send_row(64'd0, 1'b0);
        send_row('1, 1'b0);
        send_row(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
        send_row(64'd0, 1'b1);
        send_row(64'd0, 1'b0);
        for (c = 0; c < 5; c++)
            send_row(bucket_row('1, c), 1'b0);
        send_row(bucket_row('1, 3), 1'b0);
        send_row(bucket_row('0, 9), 1'b0);
        settle();
        write_limit('0);
        send_row(64'd7, 1'b0);
        send_row(64'd0, 1'b1);
        settle();
        write_limit(64'd6);
        send_row(64'd5, 1'b0);
        send_row(64'd6, 1'b0);
        send_row(64'd5, 1'b0);
        send_row(64'd5, 1'b1);

        run_phase('1, 420, 1);
        run_phase('0, 60, 0);
        run_phase(64'd1, 80, 0);
        run_phase({$urandom, $urandom}, 250, 0);
        calm = 1;
        run_phase(64'h8000_0000_0000_0000, 250, 0);
        calm = 0;
        run_phase({$urandom, $urandom}, 250, 0);
        run_phase('1, 400, 1);

        settle();
        repeat (32) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("** batch_row_dedup_hash_top: PASSED **");
        else
            $display("** batch_row_dedup_hash_top: FAILED **");
        $finish;
    end

endmodule

[files.f]
hw/rtl/brdh_pkg.sv
hw/rtl/brdh_hash.sv
hw/rtl/brdh_mem.sv
hw/rtl/brdh_seq.sv
hw/rtl/batch_row_dedup_hash_top.sv
tb/sv/batch_row_dedup_hash_top_test.sv
